/* design/joystick_direction_decoder_assert.svh */
// ----------------------------------------------------------------------------
// Joystick direction decoder assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_DIRECTION_DECODER_ASSERT_SVH
`define JOYSTICK_DIRECTION_DECODER_ASSERT_SVH

// Same-cycle implication
`define JDD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("joystick direction decoder: same-cycle check failed");

// Next-cycle implication
`define JDD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("joystick direction decoder: next-cycle check failed");

`endif

/* design/jdd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick direction decoder package
// Request and result types, register indexes, constants and trig tables.
// ----------------------------------------------------------------------------
package jdd_pkg;

    // Request payload
    typedef struct packed {
        logic [7:0] x_sample;
        logic [7:0] y_sample;
        logic       button_active;
    } t_jdd_in;

    // Result payload
    typedef struct packed {
        logic       press_event;
        logic       button_held;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic       deflected;
        logic       angle_event;
        logic [8:0] angle_deg;
        logic       sector_event;
        logic [2:0] sector;
    } t_jdd_out;

    // Register indexes
    localparam logic [1:0] CFG_THRESHOLD    = 2'd0;
    localparam logic [1:0] CFG_ANGLE_EVENTS = 2'd1;
    localparam logic [1:0] CFG_SECTOR_EVENTS = 2'd2;

    // Axis and angle constants
    localparam logic [7:0] AXIS_CENTER = 8'd127;
    localparam logic [6:0] FINE_MAX    = 7'd89;
    localparam logic [6:0] FINE_DIAG   = 7'd45;
    localparam int         SEC_ROUND   = 180;
    localparam int         DEG_FULL    = 360;
    localparam int         DIV_SHIFT   = 21;

    // Trig tables: Q40 unsigned, one entry per whole degree of a quadrant
    localparam int TRIG_W = 40;
    typedef logic [TRIG_W-1:0] t_trig_tab [0:89];

    localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
    localparam logic [63:0] ONE_Q60 = 64'h1000000000000000;

    // Truncating Q60 product
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // Build the cosine or sine table by repeated one-degree rotation
    function automatic t_trig_tab build_trig(input logic want_sin);
        logic [63:0] x, x2, x3, x4, x5, x6, x7, x8, c1, s1, ck, sk;
        logic [63:0] c [0:45];
        logic [63:0] s [0:45];
        t_trig_tab   tab;
        x  = PI_Q60 / 64'd180;
        x2 = mul_q60(x, x);
        x3 = mul_q60(x2, x);
        x4 = mul_q60(x2, x2);
        x5 = mul_q60(x4, x);
        x6 = mul_q60(x4, x2);
        x7 = mul_q60(x6, x);
        x8 = mul_q60(x4, x4);
        c1 = ONE_Q60 - x2 / 64'd2 + x4 / 64'd24 - x6 / 64'd720 + x8 / 64'd40320;
        s1 = x - x3 / 64'd6 + x5 / 64'd120 - x7 / 64'd5040;
        c[0] = ONE_Q60;
        s[0] = 64'd0;
        for (int k = 1; k <= 45; k++) begin
            c[k] = mul_q60(c[k-1], c1) - mul_q60(s[k-1], s1);
            s[k] = mul_q60(s[k-1], c1) + mul_q60(c[k-1], s1);
        end
        for (int k = 0; k < 90; k++) begin
            if (k <= 45) begin
                ck = c[k];
                sk = s[k];
            end else begin
                ck = s[90-k];
                sk = c[90-k];
            end
            tab[k] = want_sin ? sk[59:20] : ck[59:20];
        end
        return tab;
    endfunction

    localparam t_trig_tab COS_TAB = build_trig(1'b0);
    localparam t_trig_tab SIN_TAB = build_trig(1'b1);

    // Start of each quadrant in degrees
    function automatic logic [8:0] quad_base(input logic [1:0] q);
        logic [8:0] b;
        case (q)
            2'd0:    b = 9'd0;
            2'd1:    b = 9'd90;
            2'd2:    b = 9'd180;
            default: b = 9'd270;
        endcase
        return b;
    endfunction

endpackage

/* design/joystick_direction_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick direction decoder
// Button edge, deflection test, whole-degree angle and sector events.
// ----------------------------------------------------------------------------
// One request is taken at a time. A request below the threshold goes from the
// squares for the radius and the threshold straight to loading its result; a
// deflected one then runs a binary search of six or seven probes over the 89
// degree boundaries of the quadrant, each probe a cosine and then a sine
// product on one shared 16x40 multiplier, and one reciprocal multiply for the
// sector. A deflected center point, possible only with a zero threshold, skips
// the search. The next request can be taken in the cycle after a result is
// loaded. The result waits in an output register, so the next request is
// taken while it is still stalled.
// ----------------------------------------------------------------------------
`include "joystick_direction_decoder_assert.svh"

module joystick_direction_decoder #(
    parameter int SECTORS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  jdd_pkg::t_jdd_in i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output jdd_pkg::t_jdd_out o_out,
    input  logic             i_cfg_wr_en,
    input  logic [1:0]       i_cfg_index,
    input  logic [7:0]       i_cfg_data
);

    localparam int SW    = $clog2(SECTORS);
    localparam int QW    = $clog2(SECTORS + 1);
    localparam int TMAX  = 359 * SECTORS + jdd_pkg::SEC_ROUND;
    localparam int TW    = $clog2(TMAX + 1);
    localparam int RECIP = (2 ** jdd_pkg::DIV_SHIFT + jdd_pkg::DEG_FULL - 1) / jdd_pkg::DEG_FULL;
    localparam int PW    = 16 + jdd_pkg::TRIG_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DX   = 4'd1;
    localparam logic [3:0] S_DY   = 4'd2;
    localparam logic [3:0] S_TH   = 4'd3;
    localparam logic [3:0] S_MA   = 4'd4;
    localparam logic [3:0] S_MB   = 4'd5;
    localparam logic [3:0] S_SEC  = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_UPD  = 4'd8;

    logic [3:0] r_state, n_state;

    // Configuration and stored state
    logic [7:0]    r_thr;
    logic          r_aen, r_sen;
    logic          r_last_btn;
    logic [8:0]    r_held_ang;
    logic          r_arearm;
    logic [SW-1:0] r_held_sec;
    logic          r_srearm;

    // Working registers
    logic [7:0]    r_x, r_y;
    logic          r_btn, r_press;
    logic [7:0]    r_adx, r_ady, r_u, r_v;
    logic [1:0]    r_quad;
    logic          r_center;
    logic [15:0]   r_r2;
    logic          r_defl;
    logic [6:0]    r_lo, r_hi, r_mid;
    logic [47:0]   r_prod;
    logic [8:0]    r_ang;
    logic [TW-1:0] r_t;
    logic [SW-1:0] r_sec;

    // Output register
    logic              r_out_vld;
    jdd_pkg::t_jdd_out r_out;

    logic                      in_fire, upd_fire;
    logic signed [8:0]         dx, dy;
    logic [7:0]                adx, ady;
    logic [15:0]               mul_a;
    logic [jdd_pkg::TRIG_W-1:0] mul_b;
    logic [PW-1:0]             prod;
    logic [6:0]                mid;
    logic                      hit;
    logic [8:0]                ang;
    logic [QW-1:0]             quo;
    logic                      aev, sev;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_fire     = i_in_valid && !o_in_stall;
    assign upd_fire    = (r_state == S_UPD) && (!r_out_vld || !i_out_stall);
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    // Center the axes and take magnitudes
    assign dx  = $signed({1'b0, i_in.x_sample}) - $signed({1'b0, jdd_pkg::AXIS_CENTER});
    assign dy  = $signed({1'b0, i_in.y_sample}) - $signed({1'b0, jdd_pkg::AXIS_CENTER});
    assign adx = dx[8] ? 8'(-dx) : dx[7:0];
    assign ady = dy[8] ? 8'(-dy) : dy[7:0];

    // Midpoint of the search range, rounded up
    assign mid = 7'(({1'b0, r_lo} + {1'b0, r_hi} + 8'd1) >> 1);

    // Shared multiplier operand select
    always_comb begin
        mul_a = 16'd0;
        mul_b = '0;
        unique case (r_state)
            S_DX: begin
                mul_a = 16'(r_adx);
                mul_b = jdd_pkg::TRIG_W'(r_adx);
            end
            S_DY: begin
                mul_a = 16'(r_ady);
                mul_b = jdd_pkg::TRIG_W'(r_ady);
            end
            S_TH: begin
                mul_a = 16'(r_thr);
                mul_b = jdd_pkg::TRIG_W'(r_thr);
            end
            S_MA: begin
                mul_a = 16'(r_v);
                mul_b = jdd_pkg::COS_TAB[mid];
            end
            S_MB: begin
                mul_a = 16'(r_u);
                mul_b = jdd_pkg::SIN_TAB[r_mid];
            end
            S_DIV: begin
                mul_a = 16'(RECIP);
                mul_b = jdd_pkg::TRIG_W'(r_t);
            end
            default: begin
                mul_a = 16'd0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = PW'(mul_a) * PW'(mul_b);

    // Boundary test: at or past the probed degree
    assign hit = (r_mid == jdd_pkg::FINE_DIAG) ? (r_v >= r_u) : (r_prod >= prod[47:0]);

    assign ang = r_center ? 9'd0 : 9'(jdd_pkg::quad_base(r_quad) + 9'(r_lo));
    assign quo = prod[jdd_pkg::DIV_SHIFT +: QW];

    // Event decisions for the finished request
    assign aev = r_defl && r_aen && (r_arearm || (r_held_ang != r_ang));
    assign sev = r_defl && r_sen && (r_srearm || (r_held_sec != r_sec));

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_fire) n_state = S_DX;
            S_DX:   n_state = S_DY;
            S_DY:   n_state = S_TH;
            S_TH:   n_state = (r_r2 >= prod[15:0]) ? S_MA : S_UPD;
            S_MA:   n_state = (r_lo == r_hi) ? S_SEC : S_MB;
            S_MB:   n_state = S_MA;
            S_SEC:  n_state = S_DIV;
            S_DIV:  n_state = S_UPD;
            S_UPD:  if (upd_fire) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control state, configuration and held values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_thr      <= 8'd0;
            r_aen      <= 1'b0;
            r_sen      <= 1'b0;
            r_last_btn <= 1'b0;
            r_held_ang <= 9'd0;
            r_arearm   <= 1'b1;
            r_held_sec <= '0;
            r_srearm   <= 1'b1;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            // Take register writes
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    jdd_pkg::CFG_THRESHOLD:     r_thr <= i_cfg_data;
                    jdd_pkg::CFG_ANGLE_EVENTS:  r_aen <= i_cfg_data[0];
                    jdd_pkg::CFG_SECTOR_EVENTS: r_sen <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (in_fire) begin
                r_last_btn <= i_in.button_active;
            end
            // Commit events and rearm below threshold
            if (upd_fire) begin
                if (r_defl) begin
                    if (aev) begin
                        r_held_ang <= r_ang;
                        r_arearm   <= 1'b0;
                    end
                    if (sev) begin
                        r_held_sec <= r_sec;
                        r_srearm   <= 1'b0;
                    end
                end else begin
                    r_arearm <= 1'b1;
                    r_srearm <= 1'b1;
                end
            end
            // Hold the result until taken
            if (upd_fire) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_x      <= i_in.x_sample;
            r_y      <= i_in.y_sample;
            r_btn    <= i_in.button_active;
            r_press  <= i_in.button_active && !r_last_btn;
            r_adx    <= adx;
            r_ady    <= ady;
            r_center <= (dx == 9'sd0) && (dy == 9'sd0);
            // Fold into the first quadrant
            if (!dx[8] && (dx != 9'sd0) && !dy[8]) begin
                r_quad <= 2'd0;
                r_u    <= adx;
                r_v    <= ady;
            end else if ((dx[8] || (dx == 9'sd0)) && !dy[8] && (dy != 9'sd0)) begin
                r_quad <= 2'd1;
                r_u    <= ady;
                r_v    <= adx;
            end else if (dx[8]) begin
                r_quad <= 2'd2;
                r_u    <= adx;
                r_v    <= ady;
            end else begin
                r_quad <= 2'd3;
                r_u    <= ady;
                r_v    <= adx;
            end
        end
        unique case (r_state)
            S_DX: r_r2 <= prod[15:0];
            S_DY: r_r2 <= r_r2 + prod[15:0];
            S_TH: begin
                r_defl <= (r_r2 >= prod[15:0]);
                r_lo   <= 7'd0;
                r_hi   <= r_center ? 7'd0 : jdd_pkg::FINE_MAX;
            end
            S_MA: begin
                r_mid  <= mid;
                r_prod <= prod[47:0];
            end
            S_MB: begin
                if (hit) begin
                    r_lo <= r_mid;
                end else begin
                    r_hi <= r_mid - 7'd1;
                end
            end
            S_SEC: begin
                r_ang <= ang;
                r_t   <= TW'(int'(ang) * SECTORS + jdd_pkg::SEC_ROUND);
            end
            S_DIV: r_sec <= (quo == QW'(SECTORS)) ? '0 : SW'(quo);
            default: ;
        endcase
        // Load the result register
        if (upd_fire) begin
            r_out.press_event  <= r_press;
            r_out.button_held  <= r_btn;
            r_out.pos_x        <= r_x;
            r_out.pos_y        <= r_y;
            r_out.deflected    <= r_defl;
            r_out.angle_event  <= aev;
            r_out.angle_deg    <= aev ? r_ang : r_held_ang;
            r_out.sector_event <= sev;
            r_out.sector       <= 3'(sev ? r_sec : r_held_sec);
        end
    end

    // Checks
    `JDD_ASSERT_NOW(a_search_order, (r_state == S_MA) || (r_state == S_MB), (r_lo <= r_hi) && (r_hi <= jdd_pkg::FINE_MAX))
    `JDD_ASSERT_NOW(a_probe_inside, r_state == S_MB, (r_mid > r_lo) && (r_mid <= r_hi))
    `JDD_ASSERT_NOW(a_held_angle, 1'b1, r_held_ang < 9'(jdd_pkg::DEG_FULL))
    `JDD_ASSERT_NOW(a_held_sector, 1'b1, {1'b0, r_held_sec} < (SW+1)'(SECTORS))
    `JDD_ASSERT_NEXT(a_event_deflected, upd_fire && (aev || sev), r_out.deflected && r_out_vld)

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick direction decoder testbench
// Drives sample requests through the valid/stall handshake and compares each
// result field by field with an in-bench decoder that tracks button edges,
// deflection, whole-degree angle and sector reporting. The run sweeps the
// registers, including their extremes, across phases with different idling.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int         SECTORS     = 8;
    localparam int         STICK_MID   = 127;
    localparam int         HOLD_CYCLES = 200;
    localparam int         DRAIN_WAIT  = 40;
    localparam int         PHASE_ITEMS = 92;
    localparam logic [1:0] CFG_UNUSED  = 2'd3;
    localparam logic [63:0] PI_Q60_TB  = 64'h3243F6A8885A308D;
    localparam logic [63:0] UNIT_Q60   = 64'h1000000000000000;

    // Clock, reset and block ports
    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    jdd_pkg::t_jdd_in   in_req = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    jdd_pkg::t_jdd_out  out_res;
    logic       cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    // Stimulus and scoreboard storage
    jdd_pkg::t_jdd_in  pending_reqs[$];
    jdd_pkg::t_jdd_out want_results[$];
    logic     in_took = 1'b0;
    int       n_errors = 0;
    int       send_idle_pct = 0;
    int       stall_pct = 0;
    int       hold_req_id = 0;
    int       hold_ack_id = 0;
    int       hold_left = 0;

    // Decoder model: registers and reporting state
    logic [7:0] thr_cfg = 8'd0;
    logic       angle_en = 1'b0;
    logic       sector_en = 1'b0;
    logic       btn_prev = 1'b0;
    int         rep_angle = 0;
    logic       angle_armed = 1'b1;
    int         rep_sector = 0;
    logic       sector_armed = 1'b1;
    longint     cos_q55 [0:89];
    longint     sin_q55 [0:89];

    // Random walk position for the sample stream
    int walk_x = STICK_MID;
    int walk_y = STICK_MID;
    int walk_btn = 0;

    joystick_direction_decoder #(
        .SECTORS(SECTORS)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in       (in_req),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out      (out_res),
        .i_cfg_wr_en(cfg_wr_en),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always #10 clk = ~clk;

    // Truncating product of two Q60 fractions
    function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[123:60];
    endfunction

    // Build the Q55 cosine and sine tables for whole degrees of a quadrant
    initial begin : trig_setup
        logic [63:0] st, st2, st3, st4, st5, st6, st7, st8, c1, s1, ck, sk;
        logic [63:0] cq [0:45];
        logic [63:0] sq [0:45];
        st  = PI_Q60_TB / 64'd180;
        st2 = q60_mul(st, st);
        st3 = q60_mul(st2, st);
        st4 = q60_mul(st2, st2);
        st5 = q60_mul(st4, st);
        st6 = q60_mul(st4, st2);
        st7 = q60_mul(st6, st);
        st8 = q60_mul(st4, st4);
        c1 = UNIT_Q60 - st2 / 64'd2 + st4 / 64'd24 - st6 / 64'd720 + st8 / 64'd40320;
        s1 = st - st3 / 64'd6 + st5 / 64'd120 - st7 / 64'd5040;
        cq[0] = UNIT_Q60;
        sq[0] = 64'd0;
        for (int k = 1; k <= 45; k++) begin
            cq[k] = q60_mul(cq[k-1], c1) - q60_mul(sq[k-1], s1);
            sq[k] = q60_mul(sq[k-1], c1) + q60_mul(cq[k-1], s1);
        end
        for (int k = 0; k < 90; k++) begin
            ck = (k <= 45) ? cq[k] : sq[90-k];
            sk = (k <= 45) ? sq[k] : cq[90-k];
            cos_q55[k] = longint'(ck >> 5);
            sin_q55[k] = longint'(sk >> 5);
        end
    end

    // Whole degrees of the stick direction, 0 at the center point
    function automatic int stick_angle(input int dx, input int dy);
        int  u, v, q, f;
        bit  run, past;
        if (dx == 0 && dy == 0) begin
            return 0;
        end
        if (dx > 0 && dy >= 0) begin
            q = 0; u = dx;  v = dy;
        end else if (dx <= 0 && dy > 0) begin
            q = 1; u = dy;  v = -dx;
        end else if (dx < 0) begin
            q = 2; u = -dx; v = -dy;
        end else begin
            q = 3; u = -dy; v = dx;
        end
        f = 0;
        run = 1'b1;
        // Advance while the direction lies at or past each degree boundary
        for (int k = 1; k < 90; k++) begin
            if (run) begin
                if (k == 45) begin
                    past = (v >= u);
                end else begin
                    past = (longint'(v) * cos_q55[k] - longint'(u) * sin_q55[k]) >= 0;
                end
                if (past) begin
                    f = k;
                end else begin
                    run = 1'b0;
                end
            end
        end
        return q * 90 + f;
    endfunction

    // Decode one sample request into its result and advance the model state
    task automatic decode_sample(input jdd_pkg::t_jdd_in r, output jdd_pkg::t_jdd_out res);
        int dx, dy, ang, sec;
        bit defl;
        dx = int'(r.x_sample) - STICK_MID;
        dy = int'(r.y_sample) - STICK_MID;
        defl = (dx * dx + dy * dy) >= int'(thr_cfg) * int'(thr_cfg);
        res.press_event = !btn_prev && r.button_active;
        res.button_held = r.button_active;
        res.pos_x = r.x_sample;
        res.pos_y = r.y_sample;
        res.deflected = defl;
        res.angle_event = 1'b0;
        res.sector_event = 1'b0;
        btn_prev = r.button_active;
        if (defl) begin
            ang = stick_angle(dx, dy);
            sec = ((ang * SECTORS + 180) / 360) % SECTORS;
            if (angle_en && (angle_armed || rep_angle != ang)) begin
                angle_armed = 1'b0;
                rep_angle = ang;
                res.angle_event = 1'b1;
            end
            if (sector_en && (sector_armed || rep_sector != sec)) begin
                sector_armed = 1'b0;
                rep_sector = sec;
                res.sector_event = 1'b1;
            end
        end else begin
            angle_armed = 1'b1;
            sector_armed = 1'b1;
        end
        res.angle_deg = rep_angle[8:0];
        res.sector = rep_sector[2:0];
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endtask

    // Track register writes, predict accepted requests, check accepted results
    always @(posedge clk) begin : scoreboard
        jdd_pkg::t_jdd_out want;
        jdd_pkg::t_jdd_out pred;
        in_took <= rst_n && in_valid && !in_stall;
        if (rst_n) begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    jdd_pkg::CFG_THRESHOLD: begin
                        thr_cfg = cfg_data;
                    end
                    jdd_pkg::CFG_ANGLE_EVENTS: begin
                        angle_en = cfg_data[0];
                    end
                    jdd_pkg::CFG_SECTOR_EVENTS: begin
                        sector_en = cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
            if (in_valid && !in_stall) begin
                decode_sample(in_req, pred);
                want_results.push_back(pred);
            end
            if (out_valid && !out_stall) begin
                if (want_results.size() == 0) begin
                    $error("unexpected result: x %0d y %0d", out_res.pos_x, out_res.pos_y);
                    n_errors++;
                end else begin
                    want = want_results.pop_front();
                    check_field("press_event", want.press_event, out_res.press_event);
                    check_field("button_held", want.button_held, out_res.button_held);
                    check_field("pos_x", want.pos_x, out_res.pos_x);
                    check_field("pos_y", want.pos_y, out_res.pos_y);
                    check_field("deflected", want.deflected, out_res.deflected);
                    check_field("angle_event", want.angle_event, out_res.angle_event);
                    check_field("angle_deg", want.angle_deg, out_res.angle_deg);
                    check_field("sector_event", want.sector_event, out_res.sector_event);
                    check_field("sector", want.sector, out_res.sector);
                end
            end
        end
    end

    // Offer the next pending request, holding it while stalled
    always @(negedge clk) begin : req_driver
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_took) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                in_req <= pending_reqs.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Stall results at random, or hold off for a long stretch on request
    always @(negedge clk) begin : result_stall
        if (hold_req_id != hold_ack_id) begin
            hold_ack_id <= hold_req_id;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic add_sample(input int x, input int y, input int btn);
        jdd_pkg::t_jdd_in r;
        r.x_sample = x[7:0];
        r.y_sample = y[7:0];
        r.button_active = btn[0];
        pending_reqs.push_back(r);
    endtask

    // Wait until every request is sent and every result has come back
    task automatic drain;
        wait (pending_reqs.size() == 0 && !in_valid);
        wait (want_results.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Queue a stretch of the stick moving around, with jumps and rests
    task automatic queue_walk(input int n);
        int pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                walk_x = $urandom_range(0, 255);
                walk_y = $urandom_range(0, 255);
            end else if (pick < 22) begin
                walk_x = STICK_MID + $urandom_range(0, 40) - 20;
                walk_y = STICK_MID + $urandom_range(0, 40) - 20;
            end else if (pick < 85) begin
                walk_x = walk_x + $urandom_range(0, 6) - 3;
                walk_y = walk_y + $urandom_range(0, 6) - 3;
            end
            walk_x = (walk_x < 0) ? 0 : (walk_x > 255) ? 255 : walk_x;
            walk_y = (walk_y < 0) ? 0 : (walk_y > 255) ? 255 : walk_y;
            if ($urandom_range(0, 99) < 25) begin
                walk_btn = 1 - walk_btn;
            end
            add_sample(walk_x, walk_y, walk_btn);
        end
    endtask

    // Main sequence: reset, directed samples, then random phases
    initial begin : stimulus
        logic [7:0] thr_list [0:7];
        logic       aon_list [0:7];
        logic       son_list [0:7];
        thr_list = '{8'd0, 8'd255, 8'd30, 8'd60, 8'd100, 8'd1, 8'd128, 8'd0};
        aon_list = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
        son_list = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
        thr_list[7] = 8'($urandom_range(0, 255));

        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: zero threshold, both kinds of event enabled
        write_reg(jdd_pkg::CFG_THRESHOLD, 8'd0);
        write_reg(jdd_pkg::CFG_ANGLE_EVENTS, 8'd1);
        write_reg(jdd_pkg::CFG_SECTOR_EVENTS, 8'd1);
        add_sample(127, 127, 0);
        add_sample(127, 127, 1);
        add_sample(255, 127, 1);
        add_sample(255, 255, 0);
        add_sample(200, 200, 1);
        add_sample(127, 255, 0);
        add_sample(0, 255, 0);
        add_sample(0, 127, 1);
        add_sample(0, 0, 0);
        add_sample(127, 0, 0);
        add_sample(255, 0, 1);
        add_sample(128, 127, 0);
        add_sample(127, 126, 0);
        add_sample(255, 126, 1);
        add_sample(227, 169, 1);
        add_sample(227, 170, 0);
        drain();

        // Directed: radius exactly at the threshold, masked register data
        write_reg(jdd_pkg::CFG_THRESHOLD, 8'd128);
        write_reg(jdd_pkg::CFG_ANGLE_EVENTS, 8'h03);
        write_reg(jdd_pkg::CFG_SECTOR_EVENTS, 8'hFF);
        write_reg(CFG_UNUSED, 8'hA5);
        add_sample(255, 127, 1);
        add_sample(254, 127, 0);
        add_sample(0, 127, 1);
        add_sample(127, 255, 0);
        add_sample(255, 255, 1);
        drain();

        // Directed: events disabled by an even write
        write_reg(jdd_pkg::CFG_ANGLE_EVENTS, 8'hFE);
        write_reg(jdd_pkg::CFG_SECTOR_EVENTS, 8'h00);
        add_sample(255, 255, 0);
        add_sample(0, 0, 1);
        drain();

        // Random phases: each sets the registers and an idling pattern
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(jdd_pkg::CFG_THRESHOLD, thr_list[ph]);
            write_reg(jdd_pkg::CFG_ANGLE_EVENTS,
                      {7'($urandom_range(0, 127)), aon_list[ph]});
            write_reg(jdd_pkg::CFG_SECTOR_EVENTS,
                      {7'($urandom_range(0, 127)), son_list[ph]});
            case (ph % 4)
                0: begin
                    send_idle_pct = 0;  stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 82; stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;  stall_pct = 82;
                end
                default: begin
                    send_idle_pct = 17; stall_pct = 17;
                end
            endcase
            if (ph == 4) begin
                // Hold off results while requests keep coming
                queue_walk(PHASE_ITEMS);
                @(posedge clk);
                hold_req_id++;
            end else if (ph == 5) begin
                // Sender pauses until every result is back
                queue_walk(PHASE_ITEMS / 2);
                drain();
                queue_walk(PHASE_ITEMS / 2);
            end else begin
                queue_walk(PHASE_ITEMS);
            end
            drain();
        end

        if (want_results.size() != 0) begin
            $error("%0d results never arrived", want_results.size());
            n_errors++;
        end
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Stop a hung run
    initial begin : watchdog
        #4000000;
        $display("simulation failed");
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/jdd_pkg.sv
design/joystick_direction_decoder.sv
dv/tb_top.sv
